// ----- rtl/ir_pfd_pkg.sv -----
// Shared types, constants and helpers for the IR pulse-width frame decoder.
// Used by every module under rtl/; depends on nothing.
package ir_pfd_pkg;

   // Frame layout
   localparam int FRAME_BITS   = 12;
   localparam int CHANNEL_BITS = 5;
   localparam logic [FRAME_BITS-1:0] CHANNEL_MASK =
      FRAME_BITS'((64'd1 << CHANNEL_BITS) - 64'd1);

   // Field widths
   localparam int SAMPLE_W  = 10;
   localparam int TOL_W     = 4;
   localparam int WIDTH_W   = 8;
   localparam int TICK_W    = 7;
   localparam int TALLY_W   = 4;
   localparam int COMMAND_W = 7;
   localparam int CHANNEL_W = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE       = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd500;
   localparam logic [TOL_W-1:0]    TOLERANCE_RST = 4'd3;
   localparam logic [WIDTH_W-1:0]  START_RST     = 8'd24;
   localparam logic [WIDTH_W-1:0]  STOP_RST      = 8'd22;
   localparam logic [WIDTH_W-1:0]  ZERO_RST      = 8'd6;
   localparam logic [WIDTH_W-1:0]  ONE_RST       = 8'd12;

   // Saturation limits
   localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};
   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   // Pulse queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Width targets seen by the frame engine
   typedef struct packed {
      logic [TOL_W-1:0]   tolerance;
      logic [WIDTH_W-1:0] start_width;
      logic [WIDTH_W-1:0] stop_width;
      logic [WIDTH_W-1:0] zero_width;
      logic [WIDTH_W-1:0] one_width;
   } targets_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // True when width lies within tolerance of the target, both sides inclusive
   function automatic logic near_target(logic [WIDTH_W-1:0] width,
                                        logic [WIDTH_W-1:0] target,
                                        logic [TOL_W-1:0] tol);
      logic [WIDTH_W:0] width_hi;
      logic [WIDTH_W:0] target_hi;
      width_hi  = {1'b0, width} + {{(WIDTH_W+1-TOL_W){1'b0}}, tol};
      target_hi = {1'b0, target} + {{(WIDTH_W+1-TOL_W){1'b0}}, tol};
      return (width_hi >= {1'b0, target}) && ({1'b0, width} <= target_hi);
   endfunction

endpackage

// ----- rtl/ir_pulse_width_frame_decoder.sv -----
// IR pulse-width frame decoder, top level: register file, front end,
// pulse queue and frame engine. Depends on ir_pfd_pkg and the ir_pfd_* modules.
// Throughput: one sample per cycle while the queue has room. The stop pulse's width
// is queued, then popped into the registered result once the result register is free.
// The two-entry pulse queue and the result register set the slack between sides.
// Reset (synchronous, active high) restores register defaults, clears the queue
// and returns the engine to hunting for a start pulse.
module ir_pulse_width_frame_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [ir_pfd_pkg::REQ_DATA_W-1:0]        req_tdata,  // [9:0] sample
   // result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [ir_pfd_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [6:0] command_code,
                                                                // [11:7] channel_code,
                                                                // [15:12] bits_seen
   // configuration
   input  logic                                     csr_we,
   input  logic [ir_pfd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ir_pfd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [ir_pfd_pkg::SAMPLE_W-1:0]  threshold_ff, threshold_in;
   ir_pfd_pkg::targets_type          targets_ff, targets_in;
   ir_pfd_pkg::queue_status_type     q_status;
   logic                             sample_take;
   logic                             push, pop;
   logic [ir_pfd_pkg::WIDTH_W-1:0]   push_width, head_width;
   logic [ir_pfd_pkg::COMMAND_W-1:0] command_code;
   logic [ir_pfd_pkg::CHANNEL_W-1:0] channel_code;
   logic [ir_pfd_pkg::TALLY_W-1:0]   bits_seen;

   // Register writes
   always_comb begin
      threshold_in = threshold_ff;
      targets_in   = targets_ff;
      if (csr_we) begin
         unique case (csr_index)
            ir_pfd_pkg::CSR_THRESHOLD: threshold_in = csr_wdata;
            ir_pfd_pkg::CSR_TOLERANCE:
               targets_in.tolerance = csr_wdata[ir_pfd_pkg::TOL_W-1:0];
            ir_pfd_pkg::CSR_START:
               targets_in.start_width = csr_wdata[ir_pfd_pkg::WIDTH_W-1:0];
            ir_pfd_pkg::CSR_STOP:
               targets_in.stop_width = csr_wdata[ir_pfd_pkg::WIDTH_W-1:0];
            ir_pfd_pkg::CSR_ZERO:
               targets_in.zero_width = csr_wdata[ir_pfd_pkg::WIDTH_W-1:0];
            ir_pfd_pkg::CSR_ONE:
               targets_in.one_width = csr_wdata[ir_pfd_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff          <= ir_pfd_pkg::THRESHOLD_RST;
         targets_ff.tolerance  <= ir_pfd_pkg::TOLERANCE_RST;
         targets_ff.start_width <= ir_pfd_pkg::START_RST;
         targets_ff.stop_width <= ir_pfd_pkg::STOP_RST;
         targets_ff.zero_width <= ir_pfd_pkg::ZERO_RST;
         targets_ff.one_width  <= ir_pfd_pkg::ONE_RST;
      end else begin
         threshold_ff <= threshold_in;
         targets_ff   <= targets_in;
      end
   end

   // Samples are taken whenever the queue has room for a finished pulse
   assign req_tready  = !q_status.full;
   assign sample_take = req_tvalid && req_tready;

   ir_pfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .sample_take (sample_take),
      .sample      (req_tdata[ir_pfd_pkg::SAMPLE_W-1:0]),
      .threshold   (threshold_ff),
      .pulse_push  (push),
      .pulse_width (push_width)
   );

   ir_pfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_width (push_width),
      .pop        (pop),
      .head_width (head_width),
      .status     (q_status)
   );

   ir_pfd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .width_avail  (!q_status.empty),
      .width        (head_width),
      .targets      (targets_ff),
      .width_pop    (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .command_code (command_code),
      .channel_code (channel_code),
      .bits_seen    (bits_seen)
   );

   assign rsp_tdata = {bits_seen, channel_code, command_code};

`ifndef SYNTH
   // No pulse is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("pulse pushed into full queue");

   // The engine only consumes a pulse when the result register can take a transfer
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_tvalid || rsp_tready))
      else $error("pulse consumed while result register blocked");

   // A new result appears only after a pulse was consumed
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop))
      else $error("result appeared without a consumed pulse");

   // Nothing is consumed from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pulse consumed from empty queue");
`endif

endmodule

// ----- rtl/ir_pfd_front.sv -----
// Front end: compares each sample with the threshold and measures pulses.
// Emits one width per finished pulse. Depends on ir_pfd_pkg.
module ir_pfd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               sample_take,
   input  logic [ir_pfd_pkg::SAMPLE_W-1:0]    sample,
   input  logic [ir_pfd_pkg::SAMPLE_W-1:0]    threshold,
   output logic                               pulse_push,
   output logic [ir_pfd_pkg::WIDTH_W-1:0]     pulse_width
);

   logic                              was_active_ff, was_active_in;
   logic [ir_pfd_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic                              active;

   assign active = sample < threshold;

   // Pulse ends on the first inactive sample after an active run
   assign pulse_push  = sample_take && !active && was_active_ff;
   assign pulse_width = (tick_ff == ir_pfd_pkg::TICK_MAX) ? ir_pfd_pkg::WIDTH_MAX
                                                          : {tick_ff, 1'b0};

   // Tick counter, saturating
   always_comb begin
      was_active_in = was_active_ff;
      tick_in       = tick_ff;
      if (sample_take) begin
         if (active) begin
            was_active_in = 1'b1;
            if (tick_ff != ir_pfd_pkg::TICK_MAX) begin
               tick_in = tick_ff + 1'b1;
            end
         end else begin
            was_active_in = 1'b0;
            tick_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_active_ff <= 1'b0;
         tick_ff       <= '0;
      end else begin
         was_active_ff <= was_active_in;
         tick_ff       <= tick_in;
      end
   end

endmodule

// ----- rtl/ir_pfd_queue.sv -----
// Short queue of pulse widths between the front end and the frame engine.
// Depends on ir_pfd_pkg.
module ir_pfd_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [ir_pfd_pkg::WIDTH_W-1:0]      push_width,
   input  logic                                pop,
   output logic [ir_pfd_pkg::WIDTH_W-1:0]      head_width,
   output ir_pfd_pkg::queue_status_type        status
);

   logic [ir_pfd_pkg::WIDTH_W-1:0]  entry_ff [ir_pfd_pkg::QUEUE_DEPTH];
   logic [ir_pfd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ir_pfd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ir_pfd_pkg::QUEUE_CW-1:0] count_ff, count_in;

   assign status.full  = count_ff == ir_pfd_pkg::QUEUE_CW'(ir_pfd_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_width   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ir_pfd_pkg::QUEUE_AW'(ir_pfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ir_pfd_pkg::QUEUE_AW'(ir_pfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_width;
      end
   end

endmodule

// ----- rtl/ir_pfd_back.sv -----
// Frame engine: classifies pulse widths, assembles the frame and holds the
// result register. Depends on ir_pfd_pkg.
module ir_pfd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                width_avail,
   input  logic [ir_pfd_pkg::WIDTH_W-1:0]      width,
   input  ir_pfd_pkg::targets_type             targets,
   output logic                                width_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ir_pfd_pkg::COMMAND_W-1:0]    command_code,
   output logic [ir_pfd_pkg::CHANNEL_W-1:0]    channel_code,
   output logic [ir_pfd_pkg::TALLY_W-1:0]      bits_seen
);

   localparam logic PHASE_HUNT  = 1'b0;
   localparam logic PHASE_FRAME = 1'b1;

   logic                                 phase_ff, phase_in;
   logic [ir_pfd_pkg::FRAME_BITS-1:0]    shift_ff, shift_in;
   logic [ir_pfd_pkg::TALLY_W-1:0]       tally_ff, tally_in;
   logic                                 valid_ff, valid_in;
   logic [ir_pfd_pkg::COMMAND_W-1:0]     command_ff, command_in;
   logic [ir_pfd_pkg::CHANNEL_W-1:0]     channel_ff, channel_in;
   logic [ir_pfd_pkg::TALLY_W-1:0]       bits_ff, bits_in;
   logic                                 hit_start, hit_stop, hit_zero, hit_one;
   logic                                 new_bit, emit;
   logic [ir_pfd_pkg::FRAME_BITS-1:0]    upper_word, chan_word;

   // Take a width only when the result register can accept a transfer
   assign width_pop = width_avail && (!valid_ff || rsp_ready);

   assign hit_start = ir_pfd_pkg::near_target(width, targets.start_width, targets.tolerance);
   assign hit_stop  = ir_pfd_pkg::near_target(width, targets.stop_width, targets.tolerance);
   assign hit_zero  = ir_pfd_pkg::near_target(width, targets.zero_width, targets.tolerance);
   assign hit_one   = ir_pfd_pkg::near_target(width, targets.one_width, targets.tolerance);

   // Stop wins over zero, zero over one; unmatched pulses count as zero
   assign new_bit = !hit_zero && hit_one;
   assign emit    = width_pop && (phase_ff == PHASE_FRAME) && hit_stop;

   assign upper_word = shift_ff >> ir_pfd_pkg::CHANNEL_BITS;
   assign chan_word  = shift_ff & ir_pfd_pkg::CHANNEL_MASK;

   // Frame state
   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      tally_in = tally_ff;
      if (width_pop) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (hit_start) begin
                  phase_in = PHASE_FRAME;
                  shift_in = '0;
                  tally_in = '0;
               end
            end
            PHASE_FRAME: begin
               if (hit_stop) begin
                  phase_in = PHASE_HUNT;
               end else begin
                  shift_in = {shift_ff[ir_pfd_pkg::FRAME_BITS-2:0], new_bit};
                  if (tally_ff != ir_pfd_pkg::TALLY_MAX) begin
                     tally_in = tally_ff + 1'b1;
                  end
               end
            end
            default: phase_in = PHASE_HUNT;
         endcase
      end
   end

   // Result register
   always_comb begin
      valid_in   = valid_ff;
      command_in = command_ff;
      channel_in = channel_ff;
      bits_in    = bits_ff;
      if (emit) begin
         valid_in   = 1'b1;
         command_in = upper_word[ir_pfd_pkg::COMMAND_W-1:0];
         channel_in = chan_word[ir_pfd_pkg::CHANNEL_W-1:0];
         bits_in    = tally_ff;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         shift_ff <= '0;
         tally_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         tally_ff <= tally_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      channel_ff <= channel_in;
      bits_ff    <= bits_in;
   end

   assign rsp_valid    = valid_ff;
   assign command_code = command_ff;
   assign channel_code = channel_ff;
   assign bits_seen    = bits_ff;

endmodule

// ----- bench/ir_pulse_width_frame_decoder_tb.sv -----
// Self-checking bench for the IR pulse-width frame decoder: pulse trains in, decoded frames out.
// Carries its own scoreboard class, which tracks decoder state and configuration.
// Depends on ir_pfd_pkg and the ir_pulse_width_frame_decoder top level.
`timescale 1ns / 1ps

module ir_pulse_width_frame_decoder_tb;
   import ir_pfd_pkg::*;

   // Indexes that map to no register; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENTS      = 9;

   // Same bit order as rsp_tdata
   typedef struct packed {
      logic [TALLY_W-1:0]   bits;
      logic [CHANNEL_W-1:0] channel;
      logic [COMMAND_W-1:0] command;
   } frame_result_t;

   typedef struct {
      logic [SAMPLE_W-1:0] thr;
      logic [TOL_W-1:0]    tol;
      logic [WIDTH_W-1:0]  start_w;
      logic [WIDTH_W-1:0]  stop_w;
      logic [WIDTH_W-1:0]  zero_w;
      logic [WIDTH_W-1:0]  one_w;
   } setting_t;

   // Tracks decoder state and holds the decoded frames still owed by the block
   class frame_scoreboard;
      logic [SAMPLE_W-1:0]   threshold;
      logic [TOL_W-1:0]      tol;
      logic [WIDTH_W-1:0]    start_w, stop_w, zero_w, one_w;
      logic                  in_frame, was_active;
      logic [TICK_W-1:0]     ticks;
      logic [FRAME_BITS-1:0] frame_word;
      logic [TALLY_W-1:0]    tally;
      frame_result_t         owed[$];
      int                    mismatches, samples_seen, frames_predicted, frames_checked;

      function new();
         threshold = THRESHOLD_RST;
         tol       = TOLERANCE_RST;
         start_w   = START_RST;
         stop_w    = STOP_RST;
         zero_w    = ZERO_RST;
         one_w     = ONE_RST;
         in_frame   = 1'b0;
         was_active = 1'b0;
         ticks      = '0;
         frame_word = '0;
         tally      = '0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_THRESHOLD: threshold = val[SAMPLE_W-1:0];
            CSR_TOLERANCE: tol       = val[TOL_W-1:0];
            CSR_START:     start_w   = val[WIDTH_W-1:0];
            CSR_STOP:      stop_w    = val[WIDTH_W-1:0];
            CSR_ZERO:      zero_w    = val[WIDTH_W-1:0];
            CSR_ONE:       one_w     = val[WIDTH_W-1:0];
            default: ;
         endcase
      endfunction

      function bit close_to(logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] t);
         int d;
         d = int'(tol);
         return (int'(w) >= int'(t) - d) && (int'(w) <= int'(t) + d);
      endfunction

      // One sample transfer: measure pulses, open/extend/close frames
      function void note_sample(logic [SAMPLE_W-1:0] s);
         logic [WIDTH_W-1:0] pulse_w;
         logic               bit_in;
         frame_result_t      res;
         samples_seen++;
         if (s < threshold) begin
            if (ticks != TICK_MAX) ticks++;
            was_active = 1'b1;
            return;
         end
         if (!was_active) return;
         pulse_w    = (ticks == TICK_MAX) ? WIDTH_MAX : {ticks, 1'b0};
         was_active = 1'b0;
         ticks      = '0;
         if (!in_frame) begin
            if (close_to(pulse_w, start_w)) begin
               in_frame   = 1'b1;
               frame_word = '0;
               tally      = '0;
            end
            return;
         end
         // stop wins over the bit targets
         if (close_to(pulse_w, stop_w)) begin
            res.command = frame_word[FRAME_BITS-1:CHANNEL_BITS];
            res.channel = frame_word[CHANNEL_BITS-1:0];
            res.bits    = tally;
            owed.push_back(res);
            frames_predicted++;
            in_frame = 1'b0;
            return;
         end
         // zero checked before one; anything unmatched counts as a zero
         bit_in     = close_to(pulse_w, zero_w) ? 1'b0 : close_to(pulse_w, one_w);
         frame_word = {frame_word[FRAME_BITS-2:0], bit_in};
         if (tally != TALLY_MAX) tally++;
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         frame_result_t got, want;
         got = data;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected frame cmd=%0d chan=%0d bits=%0d",
                        $time, got.command, got.channel, got.bits);
            return;
         end
         want = owed.pop_front();
         frames_checked++;
         if (got.command !== want.command || got.channel !== want.channel ||
             got.bits !== want.bits) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: frame %0d: cmd %0d/%0d chan %0d/%0d bits %0d/%0d (exp/got)",
                        $time, frames_checked, want.command, got.command,
                        want.channel, got.channel, want.bits, got.bits);
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // [9:0] sample
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // [6:0] command_code, [11:7] channel_code,
                                              // [15:12] bits_seen
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int send_idle = 36;
   int rcv_idle  = 68;
   frame_scoreboard sb = new();

   ir_pulse_width_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Result side: random back-pressure, check every transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99, 0) >= rcv_idle);
      end
   end

   // Hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("ir_pulse_width_frame_decoder_tb NOT OK");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] quiet_sample();
      return SAMPLE_W'($urandom_range(1023, int'(sb.threshold)));
   endfunction

   function automatic logic [SAMPLE_W-1:0] carrier_sample();
      if (sb.threshold == '0) return quiet_sample();
      return SAMPLE_W'($urandom_range(int'(sb.threshold) - 1, 0));
   endfunction

   // Tick count for a pulse aimed at target, jittered within tolerance, now and then off it
   function automatic int ticks_for(logic [WIDTH_W-1:0] target);
      int slack, w;
      slack = int'(sb.tol);
      w = int'(target) + int'($urandom_range(2 * slack, 0)) - slack;
      if ($urandom_range(19, 0) == 0) w = w + int'($urandom_range(8, 0)) - 4;
      if (w >= 254) return 127 + int'($urandom_range(3, 0));
      if (w < 2) return 1;
      return w / 2;
   endfunction

   task automatic put_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99, 0) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s);
   endtask

   task automatic send_pulse(input int n_active, input int n_gap);
      repeat (n_active) put_sample(carrier_sample());
      repeat (n_gap) put_sample(quiet_sample());
   endtask

   // Raw samples, now and then a saturating pulse
   task automatic send_noise();
      if ($urandom_range(7, 0) == 0)
         send_pulse(127 + int'($urandom_range(8, 0)), 2);
      else
         repeat ($urandom_range(12, 1)) put_sample(SAMPLE_W'($urandom_range(1023, 0)));
   endtask

   // Start, bits, stop; a few bits are off-target and a few frames lose their stop
   task automatic send_frame();
      int  nbits;
      bit  slow;
      slow = (sb.start_w > 64) || (sb.stop_w > 64) || (sb.zero_w > 64) || (sb.one_w > 64);
      if (slow) nbits = $urandom_range(3, 0);
      else if ($urandom_range(3, 0) == 0) nbits = $urandom_range(16, 0);
      else nbits = FRAME_BITS;
      send_pulse(ticks_for(sb.start_w), $urandom_range(4, 1));
      repeat (nbits) begin
         if ($urandom_range(19, 0) == 0)
            send_pulse($urandom_range(20, 1), $urandom_range(4, 1));
         else
            send_pulse(ticks_for($urandom_range(1, 0) ? sb.one_w : sb.zero_w),
                       $urandom_range(4, 1));
      end
      if ($urandom_range(9, 0) != 0) send_pulse(ticks_for(sb.stop_w), $urandom_range(4, 1));
   endtask

   // Hold the sender until every owed frame is out and the pipeline has drained
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Low bits carry the value, bits above the register width are junk
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int val,
                            input logic [CSR_DATA_W-1:0] mask);
      logic [CSR_DATA_W-1:0] word;
      word = (CSR_DATA_W'($urandom_range(1023, 0)) & ~mask) | (CSR_DATA_W'(val) & mask);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      sb.set_reg(idx, word);
      @(posedge clock);
   endtask

   task automatic apply_setting(input setting_t st);
      write_reg(CSR_THRESHOLD, int'(st.thr), 10'h3FF);
      write_reg(CSR_TOLERANCE, int'(st.tol), 10'h00F);
      write_reg(CSR_START, int'(st.start_w), 10'h0FF);
      write_reg(CSR_STOP, int'(st.stop_w), 10'h0FF);
      write_reg(CSR_ZERO, int'(st.zero_w), 10'h0FF);
      write_reg(CSR_ONE, int'(st.one_w), 10'h0FF);
      write_reg($urandom_range(1, 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                int'($urandom_range(1023, 0)), 10'h3FF);
      csr_we <= 1'b0;
   endtask

   function automatic setting_t pick_setting(input int seg);
      setting_t st;
      case (seg)
         0: st = '{THRESHOLD_RST, TOLERANCE_RST, START_RST, STOP_RST, ZERO_RST, ONE_RST};
         1: st = '{10'd1023, 4'd0, 8'd2, 8'd6, 8'd2, 8'd4};
         // stop and both bit targets overlap
         2: st = '{10'd500, 4'd15, 8'd20, 8'd20, 8'd10, 8'd12};
         // saturating start and one pulses, single active code
         3: st = '{10'd1, 4'd15, 8'd255, 8'd0, 8'd40, 8'd255};
         // nothing can be active
         4: st = '{10'd0, 4'd0, 8'd0, 8'd255, 8'd255, 8'd0};
         default: begin
            st.thr     = SAMPLE_W'($urandom_range(1023, 100));
            st.tol     = TOL_W'($urandom_range(15, 0));
            st.start_w = WIDTH_W'($urandom_range(40, 2));
            st.stop_w  = WIDTH_W'($urandom_range(40, 2));
            st.zero_w  = WIDTH_W'($urandom_range(40, 2));
            st.one_w   = WIDTH_W'($urandom_range(40, 2));
         end
      endcase
      return st;
   endfunction

   initial begin
      int seg, items0, frames0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short pulses, tolerance zero
      apply_setting('{10'd500, 4'd0, 8'd2, 8'd6, 8'd2, 8'd4});
      put_sample(10'd0);   put_sample(10'd0);   put_sample(10'd1023); // no match while hunting
      put_sample(10'd0);   put_sample(10'd1023);                      // start
      put_sample(10'd499); put_sample(10'd0);   put_sample(10'd500);  // one
      put_sample(10'd1);   put_sample(10'd1022);                      // zero
      repeat (4) put_sample(10'd0);
      put_sample(10'd600);                                            // off-target bit
      repeat (3) put_sample(10'd0);
      put_sample(10'd1023);                                           // stop
      settle();

      // Random: three idling modes, three register settings each
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) begin
            send_idle = 68;
            rcv_idle  = 36;
         end else if (seg == 6) begin
            send_idle = 0;
            rcv_idle  = 0;
         end
         settle();
         apply_setting(pick_setting(seg));
         items0  = sb.samples_seen;
         frames0 = sb.frames_predicted;
         while (!((sb.samples_seen - items0 >= 120) &&
                  (sb.frames_predicted - frames0 >= 1 || sb.samples_seen - items0 >= 220))) begin
            if ($urandom_range(6, 0) == 0) send_noise();
            else send_frame();
         end
      end
      settle();
      repeat (16) @(posedge clock);

      if (sb.pending() > 0) begin
         sb.mismatches++;
         $display("%0d decoded frames never arrived", sb.pending());
      end
      $display("Sent %0d samples over %0d register settings and three idling modes;",
               sb.samples_seen, SEGMENTS + 1);
      $display("checked %0d decoded frames, %0d mismatches", sb.frames_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("ir_pulse_width_frame_decoder_tb OK");
      else
         $display("ir_pulse_width_frame_decoder_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ir_pfd_pkg.sv
rtl/ir_pfd_front.sv
rtl/ir_pfd_queue.sv
rtl/ir_pfd_back.sv
rtl/ir_pulse_width_frame_decoder.sv
bench/ir_pulse_width_frame_decoder_tb.sv
